[hw/rtl/pffe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphase FIR front end package
// Shared constants, codes, types and the output rounding function.
// ----------------------------------------------------------------------------
package pffe_pkg;

   localparam int MAX_CHANNELS = 512;
   localparam int MAX_TAPS     = 8;
   localparam int MAX_STREAMS  = 4;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEFF_WIDTH  = 18;
   localparam int OUT_WIDTH    = 24;

   localparam int CH_W       = $clog2(MAX_CHANNELS);
   localparam int CH_CNT_W   = $clog2(MAX_CHANNELS + 1);
   localparam int TAP_W      = $clog2(MAX_TAPS);
   localparam int TAP_CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int STREAM_W   = $clog2(MAX_STREAMS);
   localparam int HIST_AW    = STREAM_W + TAP_W + CH_W;
   localparam int COEF_AW    = $clog2(MAX_TAPS * MAX_CHANNELS);
   localparam int PROD_W     = SAMPLE_WIDTH + COEFF_WIDTH;
   localparam int ACC_W      = PROD_W + TAP_W;
   localparam int RND_SHIFT  = COEFF_WIDTH - 1;
   localparam int RND_Q_W    = ACC_W + 1 - RND_SHIFT;
   localparam int SAT_W      = ((RND_Q_W > OUT_WIDTH) ? RND_Q_W : OUT_WIDTH) + 1;

   localparam int CSR_DATA_W = CH_CNT_W;

   localparam logic [CH_CNT_W-1:0]  CHANNELS_RESET = CH_CNT_W'(MAX_CHANNELS);
   localparam logic [TAP_CNT_W-1:0] TAPS_RESET     = TAP_CNT_W'(MAX_TAPS);
   localparam logic [CH_CNT_W-1:0]  CHANNELS_MIN   = CH_CNT_W'(2);
   localparam logic [TAP_CNT_W-1:0] TAPS_MIN       = TAP_CNT_W'(1);

   localparam logic OP_COEFF  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic CSR_CHANNELS = 1'b0;
   localparam logic CSR_TAPS     = 1'b1;

   // Input beat layout, lowest bits first.
   localparam int REQ_STREAM_LSB = 0;
   localparam int REQ_CIDX_LSB   = REQ_STREAM_LSB + STREAM_W;
   localparam int REQ_CVAL_LSB   = REQ_CIDX_LSB + COEF_AW;
   localparam int REQ_RE_LSB     = REQ_CVAL_LSB + COEFF_WIDTH;
   localparam int REQ_IM_LSB     = REQ_RE_LSB + SAMPLE_WIDTH;
   localparam int REQ_BITS       = REQ_IM_LSB + SAMPLE_WIDTH;
   localparam int REQ_DATA_W     = ((REQ_BITS + 7) / 8) * 8;

   // Output beat layout, lowest bits first.
   localparam int RSP_BITS   = STREAM_W + CH_W + 2 * OUT_WIDTH;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic ready;
      logic clear;
      logic walk;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic last_tap;
      logic busy;
      logic out_free;
   } dp_status_type;

   localparam logic signed [ACC_W:0]     RND_HALF = (ACC_W + 1)'(1) <<< (RND_SHIFT - 1);
   localparam logic signed [SAT_W-1:0]   SAT_MAX  = (SAT_W'(1) <<< (OUT_WIDTH - 1)) - SAT_W'(1);
   localparam logic signed [SAT_W-1:0]   SAT_MIN  = -SAT_MAX - SAT_W'(1);

   function automatic logic signed [OUT_WIDTH-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W:0]     v;
      logic signed [RND_Q_W-1:0] q;
      logic signed [SAT_W-1:0]   qx;
      logic signed [OUT_WIDTH-1:0] r;
      v  = (ACC_W + 1)'(acc) + RND_HALF;
      q  = v[ACC_W:RND_SHIFT];
      qx = SAT_W'(q);
      if (qx > SAT_MAX) begin
         r = OUT_WIDTH'(SAT_MAX);
      end else if (qx < SAT_MIN) begin
         r = OUT_WIDTH'(SAT_MIN);
      end else begin
         r = OUT_WIDTH'(qx);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/pffe_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphase FIR front end controller
// Sequences the history clear, beat acceptance, the tap walk and result load.
// ----------------------------------------------------------------------------
module pffe_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   input  wire                     req_op,
   input  pffe_pkg::dp_status_type status,
   output pffe_pkg::ctrl_cmd_type  cmd
);

   pffe_pkg::state_type state_ff;
   pffe_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pffe_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = pffe_pkg::ST_IDLE;
            end
         end
         pffe_pkg::ST_IDLE: begin
            if (req_tvalid && req_op == pffe_pkg::OP_SAMPLE) begin
               state_in = pffe_pkg::ST_WALK;
            end
         end
         pffe_pkg::ST_WALK: begin
            if (status.last_tap) begin
               state_in = pffe_pkg::ST_DRAIN;
            end
         end
         pffe_pkg::ST_DRAIN: begin
            if (!status.busy) begin
               state_in = pffe_pkg::ST_OUT;
            end
         end
         pffe_pkg::ST_OUT: begin
            if (status.out_free) begin
               state_in = pffe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pffe_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         pffe_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         pffe_pkg::ST_IDLE: begin
            cmd.ready = 1'b1;
         end
         pffe_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
         end
         pffe_pkg::ST_OUT: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pffe_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/pffe_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphase FIR front end datapath
// History and coefficient memories, stream positions, complex MAC, output.
// ----------------------------------------------------------------------------
module pffe_dpath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  pffe_pkg::ctrl_cmd_type                cmd,
   output pffe_pkg::dp_status_type               status,
   input  wire                                   pos_clear,
   input  wire [pffe_pkg::CH_CNT_W-1:0]          chans,
   input  wire [pffe_pkg::TAP_CNT_W-1:0]         taps,
   input  wire                                   req_tvalid,
   input  wire                                   req_tuser,
   input  wire [pffe_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic                                  rsp_tlast,
   output logic [pffe_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int STREAM_W  = pffe_pkg::STREAM_W;
   localparam int CH_W      = pffe_pkg::CH_W;
   localparam int CH_CNT_W  = pffe_pkg::CH_CNT_W;
   localparam int TAP_W     = pffe_pkg::TAP_W;
   localparam int TAP_CNT_W = pffe_pkg::TAP_CNT_W;
   localparam int HIST_AW   = pffe_pkg::HIST_AW;
   localparam int COEF_AW   = pffe_pkg::COEF_AW;
   localparam int SW        = pffe_pkg::SAMPLE_WIDTH;
   localparam int CW        = pffe_pkg::COEFF_WIDTH;
   localparam int OW        = pffe_pkg::OUT_WIDTH;
   localparam int ACC_W     = pffe_pkg::ACC_W;
   localparam int PROD_W    = pffe_pkg::PROD_W;

   logic [2*SW-1:0] hist_mem [2**HIST_AW];
   logic [CW-1:0]   coef_mem [2**COEF_AW];

   logic [STREAM_W-1:0]     in_stream;
   logic [COEF_AW-1:0]      in_cidx;
   logic [CW-1:0]           in_cval;
   logic [SW-1:0]           in_re;
   logic [SW-1:0]           in_im;
   logic                    accept;
   logic                    sample_acc;
   logic                    coef_we;

   logic [CH_W-1:0]         pos_ff [pffe_pkg::MAX_STREAMS];
   logic [CH_W-1:0]         pos_in [pffe_pkg::MAX_STREAMS];
   logic [TAP_W-1:0]        slot_ff [pffe_pkg::MAX_STREAMS];
   logic [TAP_W-1:0]        slot_in [pffe_pkg::MAX_STREAMS];

   logic [CH_W-1:0]         ch;
   logic [TAP_W-1:0]        slot;
   logic [CH_CNT_W-1:0]     ch_inc;
   logic [TAP_CNT_W-1:0]    slot_inc;
   logic [TAP_W-1:0]        slot_next;
   logic                    ch_wrap;

   logic [HIST_AW-1:0]      clr_addr_ff;
   logic [HIST_AW-1:0]      clr_addr_in;

   logic                    hist_we;
   logic [HIST_AW-1:0]      hist_waddr;
   logic [2*SW-1:0]         hist_wdata;
   logic [HIST_AW-1:0]      hist_raddr;
   logic [2*SW-1:0]         hist_q_ff;
   logic [CW-1:0]           coef_q_ff;

   logic [STREAM_W-1:0]     cur_stream_ff;
   logic [CH_W-1:0]         cur_ch_ff;
   logic                    cur_eob_ff;
   logic [TAP_W-1:0]        blk_ff;
   logic [TAP_W-1:0]        blk_in;
   logic [TAP_CNT_W-1:0]    blk_inc;
   logic [COEF_AW-1:0]      coef_addr_ff;
   logic [COEF_AW-1:0]      coef_addr_in;
   logic [TAP_CNT_W-1:0]    tap_cnt_ff;
   logic [TAP_CNT_W-1:0]    tap_cnt_in;

   logic                    rd_valid_ff;
   logic                    prod_valid_ff;
   logic signed [PROD_W-1:0] prod_re_ff;
   logic signed [PROD_W-1:0] prod_im_ff;
   logic signed [ACC_W-1:0] acc_re_ff;
   logic signed [ACC_W-1:0] acc_im_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [STREAM_W-1:0]     rsp_stream_ff;
   logic [CH_W-1:0]         rsp_ch_ff;
   logic                    rsp_eob_ff;
   logic signed [OW-1:0]    rsp_re_ff;
   logic signed [OW-1:0]    rsp_im_ff;

   assign in_stream = req_tdata[pffe_pkg::REQ_STREAM_LSB +: STREAM_W];
   assign in_cidx   = req_tdata[pffe_pkg::REQ_CIDX_LSB +: COEF_AW];
   assign in_cval   = req_tdata[pffe_pkg::REQ_CVAL_LSB +: CW];
   assign in_re     = req_tdata[pffe_pkg::REQ_RE_LSB +: SW];
   assign in_im     = req_tdata[pffe_pkg::REQ_IM_LSB +: SW];

   assign accept     = cmd.ready & req_tvalid;
   assign sample_acc = accept & (req_tuser == pffe_pkg::OP_SAMPLE);
   assign coef_we    = accept & (req_tuser == pffe_pkg::OP_COEFF);

   always_comb begin
      ch = pos_ff[in_stream];
      if (CH_CNT_W'(ch) >= chans) begin
         ch = '0;
      end
      slot = slot_ff[in_stream];
      if (TAP_CNT_W'(slot) >= taps) begin
         slot = '0;
      end
      ch_inc    = CH_CNT_W'(ch) + CH_CNT_W'(1);
      ch_wrap   = ch_inc >= chans;
      slot_inc  = TAP_CNT_W'(slot) + TAP_CNT_W'(1);
      slot_next = (slot_inc >= taps) ? '0 : slot_inc[TAP_W-1:0];
   end

   always_comb begin
      for (int i = 0; i < pffe_pkg::MAX_STREAMS; i++) begin
         pos_in[i]  = pos_ff[i];
         slot_in[i] = slot_ff[i];
      end
      if (pos_clear) begin
         for (int i = 0; i < pffe_pkg::MAX_STREAMS; i++) begin
            pos_in[i]  = '0;
            slot_in[i] = '0;
         end
      end else if (sample_acc) begin
         pos_in[in_stream]  = ch_wrap ? '0 : ch_inc[CH_W-1:0];
         slot_in[in_stream] = ch_wrap ? slot_next : slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pffe_pkg::MAX_STREAMS; i++) begin
            pos_ff[i]  <= '0;
            slot_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < pffe_pkg::MAX_STREAMS; i++) begin
            pos_ff[i]  <= pos_in[i];
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   assign clr_addr_in = cmd.clear ? clr_addr_ff + HIST_AW'(1) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      hist_we    = cmd.clear | sample_acc;
      hist_waddr = {in_stream, slot, ch};
      hist_wdata = {in_im, in_re};
      if (cmd.clear) begin
         hist_waddr = clr_addr_ff;
         hist_wdata = '0;
      end
   end

   assign hist_raddr = {cur_stream_ff, blk_ff, cur_ch_ff};

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_q_ff <= hist_mem[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[in_cidx] <= in_cval;
      end
      coef_q_ff <= coef_mem[coef_addr_ff];
   end

   always_comb begin
      blk_inc      = TAP_CNT_W'(blk_ff) + TAP_CNT_W'(1);
      blk_in       = blk_ff;
      coef_addr_in = coef_addr_ff;
      tap_cnt_in   = tap_cnt_ff;
      if (sample_acc) begin
         blk_in       = slot_next;
         coef_addr_in = COEF_AW'(ch);
         tap_cnt_in   = '0;
      end else if (cmd.walk) begin
         blk_in       = (blk_inc >= taps) ? '0 : blk_inc[TAP_W-1:0];
         coef_addr_in = coef_addr_ff + COEF_AW'(chans);
         tap_cnt_in   = tap_cnt_ff + TAP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      blk_ff       <= blk_in;
      coef_addr_ff <= coef_addr_in;
      tap_cnt_ff   <= tap_cnt_in;
      if (sample_acc) begin
         cur_stream_ff <= in_stream;
         cur_ch_ff     <= ch;
         cur_eob_ff    <= (ch_inc == chans);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.walk;
         prod_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff <= $signed(hist_q_ff[SW-1:0]) * $signed(coef_q_ff);
      prod_im_ff <= $signed(hist_q_ff[2*SW-1:SW]) * $signed(coef_q_ff);
      if (sample_acc) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(prod_im_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_stream_ff <= cur_stream_ff;
         rsp_ch_ff     <= cur_ch_ff;
         rsp_eob_ff    <= cur_eob_ff;
         rsp_re_ff     <= pffe_pkg::round_sat(acc_re_ff);
         rsp_im_ff     <= pffe_pkg::round_sat(acc_im_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_eob_ff;
   assign rsp_tdata  = pffe_pkg::RSP_DATA_W'({rsp_im_ff, rsp_re_ff, rsp_ch_ff, rsp_stream_ff});

   assign status.clear_last = (clr_addr_ff == {HIST_AW{1'b1}});
   assign status.last_tap   = ((tap_cnt_ff + TAP_CNT_W'(1)) == taps);
   assign status.busy       = rd_valid_ff | prod_valid_ff;
   assign status.out_free   = ~rsp_valid_ff | rsp_tready;

endmodule
`default_nettype wire

[hw/rtl/polyphase_fir_front_end.sv]
// Sample beats: a result is loaded into the output register after the single complex
// multiply-accumulate has walked the taps and drained its read and product registers;
// the next sample beat is accepted only after that load, and a waiting result holds
// off the load. A coefficient beat only writes the coefficient memory; ready stays up.
// Reset: synchronous; afterwards the history memory is cleared one entry a cycle
// over all 16384 entries; no beat is accepted meanwhile (register writes are taken).
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphase FIR front end
// Per-stream polyphase FIR stage of a channelizer with a shared complex MAC.
// ----------------------------------------------------------------------------
module polyphase_fir_front_end (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // stream, coeff_index, coeff_value, sample_re, sample_im
   input  wire [pffe_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation
   input  wire                                 req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // out_stream, out_channel, filtered_re, filtered_im, zero fill
   output logic [pffe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  wire                                 csr_we,
   input  wire                                 csr_index,
   input  wire [pffe_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   pffe_pkg::ctrl_cmd_type  cmd;
   pffe_pkg::dp_status_type status;

   logic [pffe_pkg::CH_CNT_W-1:0]  chans_reg_ff;
   logic [pffe_pkg::CH_CNT_W-1:0]  chans_reg_in;
   logic [pffe_pkg::TAP_CNT_W-1:0] taps_reg_ff;
   logic [pffe_pkg::TAP_CNT_W-1:0] taps_reg_in;
   logic [pffe_pkg::CH_CNT_W-1:0]  chans_eff;
   logic [pffe_pkg::TAP_CNT_W-1:0] taps_eff;

   always_comb begin
      chans_reg_in = chans_reg_ff;
      taps_reg_in  = taps_reg_ff;
      if (csr_we) begin
         case (csr_index)
            pffe_pkg::CSR_CHANNELS: begin
               chans_reg_in = csr_wdata[pffe_pkg::CH_CNT_W-1:0];
            end
            pffe_pkg::CSR_TAPS: begin
               taps_reg_in = csr_wdata[pffe_pkg::TAP_CNT_W-1:0];
            end
            default: begin
               chans_reg_in = chans_reg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chans_reg_ff <= pffe_pkg::CHANNELS_RESET;
         taps_reg_ff  <= pffe_pkg::TAPS_RESET;
      end else begin
         chans_reg_ff <= chans_reg_in;
         taps_reg_ff  <= taps_reg_in;
      end
   end

   always_comb begin
      chans_eff = chans_reg_ff;
      if (chans_reg_ff < pffe_pkg::CHANNELS_MIN) begin
         chans_eff = pffe_pkg::CHANNELS_MIN;
      end else if (chans_reg_ff > pffe_pkg::CHANNELS_RESET) begin
         chans_eff = pffe_pkg::CHANNELS_RESET;
      end
      taps_eff = taps_reg_ff;
      if (taps_reg_ff < pffe_pkg::TAPS_MIN) begin
         taps_eff = pffe_pkg::TAPS_MIN;
      end else if (taps_reg_ff > pffe_pkg::TAPS_RESET) begin
         taps_eff = pffe_pkg::TAPS_RESET;
      end
   end

   assign req_tready = cmd.ready;

   pffe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   pffe_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .pos_clear  (csr_we),
      .chans      (chans_eff),
      .taps       (taps_eff),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTH
   a_no_accept_while_busy : assert property (
      @(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !status.busy
   ) else $error("Beat accepted while the MAC pipeline still holds data.");

   a_result_from_load : assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.load_out)
   ) else $error("Result beat appeared without a result load.");

   a_no_accept_during_clear : assert property (
      @(posedge clock) disable iff (reset)
      cmd.clear |-> !req_tready
   ) else $error("Beat accepted during the history clear.");

   a_load_only_when_free : assert property (
      @(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready)
   ) else $error("Result loaded over a beat not yet taken.");
`endif

endmodule
`default_nettype wire
